// ===== rtl/core/b32c5_pkg.sv =====
// Shared types, constants and helper functions for the base32 / CRC5 decoder.
`default_nettype none
package b32c5_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_GROUP    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_OUT_BITS = 4'd1;

    localparam logic [5:0]  CRC_GROUP_RST    = 6'd0;
    localparam logic [15:0] MAX_OUT_BITS_RST = 16'hffff;

    // Status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_SYMBOL   = 2'd1;
    localparam logic [1:0] ST_CRC_MISMATCH = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE   = 2'd3;

    localparam logic [15:0] CRC_TOP_BIT = 16'h8000;
    localparam logic [15:0] CRC_POLY    = 16'h1070 << 3;

    localparam int QUEUE_W = 12;
    localparam int FILL_W  = 5;

    // Output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [3:0]  valid_bits;
        logic        final_report;
        logic [1:0]  status;
        logic [15:0] total_bits;
    } b32c5_item_t;

    typedef struct packed {
        logic [4:0]         crc;
        logic [5:0]         group_count;
        logic [QUEUE_W-1:0] queue;
        logic [FILL_W-1:0]  fill;
        logic [1:0]         err;
        logic               exhausted;
    } b32c5_state_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] val;
    } b32c5_sym_t;

    function automatic logic is_space(input logic [7:0] ch);
        logic r;
        case (ch) inside
            [8'd9:8'd13], 8'd32: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    // Alphabet ABCDEFGHJKLMNPQRSTUVWXYZ23456789 -> 0..31
    function automatic b32c5_sym_t sym_lookup(input logic [7:0] ch);
        b32c5_sym_t s;
        s.ok  = 1'b1;
        s.val = 5'd0;
        case (ch) inside
            [8'h41:8'h48]: s.val = 5'(ch - 8'h41);
            [8'h4a:8'h4e]: s.val = 5'(ch - 8'h42);
            [8'h50:8'h5a]: s.val = 5'(ch - 8'h43);
            [8'h32:8'h39]: s.val = 5'(ch - 8'h1a);
            default:       s.ok  = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] crc5_fold(input logic [4:0] sym, input logic [4:0] prev);
        logic [15:0] c;
        c = {3'd0, prev, 8'd0} ^ {sym, 11'd0};
        for (int k = 0; k < 5; k++)
        begin
            if ((c & CRC_TOP_BIT) != 16'd0)
            begin
                c = c ^ CRC_POLY;
            end
            c = c << 1;
        end
        return c[12:8];
    endfunction

    // Top n bits of a fill-deep queue, left-aligned in a byte
    function automatic logic [7:0] take_byte(input logic [QUEUE_W-1:0] q,
                                             input logic [FILL_W-1:0] fill,
                                             input logic [3:0] n);
        logic [QUEUE_W-1:0] s;
        logic [7:0]         b;
        s = q >> (fill - FILL_W'(n));
        b = s[7:0] << (4'd8 - n);
        return b;
    endfunction

    function automatic logic [QUEUE_W-1:0] keep_low(input logic [QUEUE_W-1:0] q,
                                                    input logic [FILL_W-1:0] fill);
        logic [QUEUE_W-1:0] r;
        if (fill >= FILL_W'(QUEUE_W))
        begin
            r = q;
        end
        else
        begin
            r = q & ~({QUEUE_W{1'b1}} << fill);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b32c5_if.sv =====
// Valid/ready channel interfaces: character input, result output, register writes.
`default_nettype none
interface b32c5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface b32c5_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [3:0]  valid_bits;
    logic        final_report;
    logic [1:0]  status;
    logic [15:0] total_bits;

    modport source (output valid, output out_byte, output valid_bits, output final_report,
                    output status, output total_bits, input ready);
    modport sink   (input valid, input out_byte, input valid_bits, input final_report,
                    input status, input total_bits, output ready);
endinterface

interface b32c5_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/b32c5_step.sv =====
// Next-state and result logic for one character or end-of-string.
`default_nettype none
module b32c5_step #(
    parameter int LENGTH_WIDTH = 16
) (
    input  b32c5_pkg::b32c5_state_t st_cur,
    input  logic [LENGTH_WIDTH-1:0] delivered_cur,
    input  logic [7:0]              char_code,
    input  logic                    end_of_string,
    input  logic [5:0]              crc_group,
    input  logic [LENGTH_WIDTH-1:0] limit,
    output b32c5_pkg::b32c5_state_t st_next,
    output logic [LENGTH_WIDTH-1:0] delivered_next,
    output logic [1:0]              n_items,
    output b32c5_pkg::b32c5_item_t  item0,
    output b32c5_pkg::b32c5_item_t  item1
);
    import b32c5_pkg::*;

    function automatic logic [3:0] cap8(input logic [LENGTH_WIDTH-1:0] r);
        logic [3:0] c;
        if (r > LENGTH_WIDTH'(8))
        begin
            c = 4'd8;
        end
        else
        begin
            c = r[3:0];
        end
        return c;
    endfunction

    b32c5_sym_t              sym;
    logic                    room;
    logic [LENGTH_WIDTH-1:0] rem0;
    logic [LENGTH_WIDTH-1:0] rem2;
    logic [LENGTH_WIDTH-1:0] deliv1;
    logic [LENGTH_WIDTH-1:0] deliv2;
    logic [LENGTH_WIDTH-1:0] deliv_fl;
    logic [QUEUE_W-1:0]      q1;
    logic [QUEUE_W-1:0]      q2;
    logic [QUEUE_W-1:0]      q3;
    logic [FILL_W-1:0]       fill1;
    logic [FILL_W-1:0]       fill2;
    logic [FILL_W-1:0]       fill3;
    logic [3:0]              d1;
    logic [3:0]              d2;
    logic [3:0]              dfl;
    logic                    take1;
    logic                    take2;
    logic                    flush;
    logic [1:0]              fin_status;
    b32c5_item_t             fl_item;
    b32c5_item_t             fin_item;

    always_comb
    begin
        sym  = sym_lookup(char_code);
        room = delivered_cur < limit;
        rem0 = limit - delivered_cur;

        // data path: push the symbol, then up to two byte takes
        q1     = {st_cur.queue[QUEUE_W-6:0], sym.val};
        fill1  = st_cur.fill + FILL_W'(5);
        d1     = cap8(rem0);
        take1  = fill1 >= FILL_W'(d1);
        fill2  = fill1 - FILL_W'(d1);
        q2     = keep_low(q1, fill2);
        deliv1 = delivered_cur + LENGTH_WIDTH'(d1);
        rem2   = rem0 - LENGTH_WIDTH'(d1);
        d2     = cap8(rem2);
        take2  = take1 && (d2 != 4'd0) && (fill2 >= FILL_W'(d2));
        fill3  = fill2 - FILL_W'(d2);
        q3     = keep_low(q2, fill3);
        deliv2 = deliv1 + LENGTH_WIDTH'(d2);

        // end-of-string flush
        flush    = (st_cur.err == ST_OK) && (st_cur.fill != '0) && room;
        dfl      = (LENGTH_WIDTH'(st_cur.fill) < rem0) ? 4'(st_cur.fill) : rem0[3:0];
        deliv_fl = flush ? delivered_cur + LENGTH_WIDTH'(dfl) : delivered_cur;
        if (st_cur.err != ST_OK)
        begin
            fin_status = st_cur.err;
        end
        else if ((crc_group != 6'd0) && (st_cur.group_count != 6'd0))
        begin
            fin_status = ST_INCOMPLETE;
        end
        else
        begin
            fin_status = ST_OK;
        end

        fl_item.out_byte     = take_byte(st_cur.queue, st_cur.fill, dfl);
        fl_item.valid_bits   = dfl;
        fl_item.final_report = 1'b0;
        fl_item.status       = ST_OK;
        fl_item.total_bits   = 16'(deliv_fl);

        fin_item.out_byte     = 8'd0;
        fin_item.valid_bits   = 4'd0;
        fin_item.final_report = 1'b1;
        fin_item.status       = fin_status;
        fin_item.total_bits   = 16'(deliv_fl);

        st_next        = st_cur;
        delivered_next = delivered_cur;
        n_items        = 2'd0;
        item0          = '0;
        item1          = '0;

        if (end_of_string)
        begin
            st_next        = '0;
            delivered_next = '0;
            if (flush)
            begin
                n_items = 2'd2;
                item0   = fl_item;
                item1   = fin_item;
            end
            else
            begin
                n_items = 2'd1;
                item0   = fin_item;
            end
        end
        else if ((st_cur.err == ST_OK) && !st_cur.exhausted && !is_space(char_code))
        begin
            if (!sym.ok)
            begin
                st_next.err = ST_BAD_SYMBOL;
            end
            else if ((crc_group != 6'd0) && (st_cur.group_count >= crc_group))
            begin
                // check symbol closes the group
                if (st_cur.crc != sym.val)
                begin
                    st_next.err = ST_CRC_MISMATCH;
                end
                st_next.crc         = 5'd0;
                st_next.group_count = 6'd0;
            end
            else
            begin
                if (crc_group != 6'd0)
                begin
                    st_next.crc         = crc5_fold(sym.val, st_cur.crc);
                    st_next.group_count = st_cur.group_count + 6'd1;
                end
                if (!room)
                begin
                    st_next.exhausted = 1'b1;
                end
                else if (!take1)
                begin
                    st_next.queue = q1;
                    st_next.fill  = fill1;
                end
                else
                begin
                    item0.out_byte   = take_byte(q1, fill1, d1);
                    item0.valid_bits = d1;
                    item0.status     = ST_OK;
                    item0.total_bits = 16'(deliv1);
                    if (take2)
                    begin
                        item1.out_byte   = take_byte(q2, fill2, d2);
                        item1.valid_bits = d2;
                        item1.status     = ST_OK;
                        item1.total_bits = 16'(deliv2);
                        n_items          = 2'd2;
                        st_next.queue    = q3;
                        st_next.fill     = fill3;
                        delivered_next   = deliv2;
                    end
                    else
                    begin
                        n_items        = 2'd1;
                        st_next.queue  = q2;
                        st_next.fill   = fill2;
                        delivered_next = deliv1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/b32c5_out_fifo.sv =====
// Result queue: takes up to two items per cycle, hands out one per transfer.
`default_nettype none
module b32c5_out_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_n,
    input  b32c5_pkg::b32c5_item_t push_item0,
    input  b32c5_pkg::b32c5_item_t push_item1,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output b32c5_pkg::b32c5_item_t out_item
);
    import b32c5_pkg::*;

    b32c5_item_t          entries_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 pop;

    assign out_valid = count_reg != '0;
    assign out_item  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case push of two, judged on registered count only
    assign room      = count_reg <= OUT_CNT_W'(OUT_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        count_next  = count_reg + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push_item0;
        end
        if (push_n == 2'd2)
        begin
            entries_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= push_item1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/base32_crc5_decoder.sv =====
// Base32 decoder with per-group CRC5 check: top level.
//
// Channels: in_ch carries one character (or an end-of-string marker) per
// transfer; out_ch carries result items (data bytes, then one closing status
// item per string); cfg_ch writes crc_group (index 0) and max_out_bits
// (index 1), always ready, and is meant to be written between strings.
// A character taken on in_ch waits in the input register until the result
// queue has room; its items leave the queue on out_ch, one per transfer.
// Throughput: one character per cycle while the queue has room. A character
// yields at most two items; a four-entry result queue takes them, and
// in_ch.ready depends only on the input register and the queue count, never
// on out_ch.ready in the same cycle. A stalled receiver fills the queue; input
// then stops after at most one more character sits in the input register.
// Reset: decode state clears, crc_group goes to 0 and max_out_bits to 65535.
// After the status item the decode state returns to its reset values; the
// registers keep their contents.
`default_nettype none
module base32_crc5_decoder #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    b32c5_in_if.sink    in_ch,
    b32c5_out_if.source out_ch,
    b32c5_cfg_if.sink   cfg_ch
);
    import b32c5_pkg::*;

    logic                    in_vld_reg;
    logic                    in_vld_next;
    logic [7:0]              in_char_reg;
    logic                    in_eos_reg;
    logic                    fire;
    logic                    fifo_room;
    logic                    in_take;

    logic [5:0]              crc_group_reg;
    logic [15:0]             max_out_bits_reg;
    logic [LENGTH_WIDTH-1:0] limit;

    b32c5_state_t            st_reg;
    b32c5_state_t            st_next;
    logic [LENGTH_WIDTH-1:0] delivered_reg;
    logic [LENGTH_WIDTH-1:0] delivered_next;
    logic [1:0]              n_items;
    b32c5_item_t             item0;
    b32c5_item_t             item1;
    b32c5_item_t             out_item;

    assign limit        = LENGTH_WIDTH'(max_out_bits_reg);
    assign fire         = in_vld_reg && fifo_room;
    assign in_ch.ready  = !in_vld_reg || fifo_room;
    assign in_take      = in_ch.valid && in_ch.ready;
    assign in_vld_next  = in_take || (in_vld_reg && !fire);
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_group_reg    <= CRC_GROUP_RST;
            max_out_bits_reg <= MAX_OUT_BITS_RST;
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == REG_CRC_GROUP)
            begin
                crc_group_reg <= cfg_ch.data[5:0];
            end
            else if (cfg_ch.index == REG_MAX_OUT_BITS)
            begin
                max_out_bits_reg <= cfg_ch.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= in_ch.char_code;
            in_eos_reg  <= in_ch.end_of_string;
        end
    end

    b32c5_step #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .st_cur         (st_reg),
        .delivered_cur  (delivered_reg),
        .char_code      (in_char_reg),
        .end_of_string  (in_eos_reg),
        .crc_group      (crc_group_reg),
        .limit          (limit),
        .st_next        (st_next),
        .delivered_next (delivered_next),
        .n_items        (n_items),
        .item0          (item0),
        .item1          (item1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            delivered_reg <= '0;
        end
        else if (fire)
        begin
            st_reg        <= st_next;
            delivered_reg <= delivered_next;
        end
    end

    b32c5_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (fire ? n_items : 2'd0),
        .push_item0 (item0),
        .push_item1 (item1),
        .room       (fifo_room),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_item   (out_item)
    );

    assign out_ch.out_byte     = out_item.out_byte;
    assign out_ch.valid_bits   = out_item.valid_bits;
    assign out_ch.final_report = out_item.final_report;
    assign out_ch.status       = out_item.status;
    assign out_ch.total_bits   = out_item.total_bits;

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_eos_reg |=> st_reg == '0 && delivered_reg == '0)
        else $error("decode state not cleared after end of string");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.err != ST_OK) && !(fire && in_eos_reg) |=> st_reg.err == $past(st_reg.err))
        else $error("latched error changed before end of string");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> in_vld_reg && !fifo_room)
        else $error("input stalled without a full result queue");

endmodule
`default_nettype wire

// ===== test/tb_base32_crc5_decoder.sv =====
// Testbench for base32_crc5_decoder: directed table, then random strings, all checked in order.
`default_nettype none
module tb_base32_crc5_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b32c5_pkg::*;

    localparam logic [255:0] ALPHABET  = "ABCDEFGHJKLMNPQRSTUVWXYZ23456789";
    localparam logic [15:0]  CRC5_POLY = 16'h8380;
    localparam int           RANDOM_CHARS = 1800;
    localparam int           N_DIRECTED   = 37;

    typedef enum logic [1:0] {ROW_CHAR, ROW_END, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  code;
        logic [3:0]  reg_index;
        logic [15:0] value;
        bit          typed;
        b32c5_item_t want;
    } stim_row_t;

    localparam b32c5_item_t NO_ITEM = '0;

    logic clk = 1'b0;
    logic rst_n;

    b32c5_in_if  in_ch();
    b32c5_out_if out_ch();
    b32c5_cfg_if cfg_ch();

    base32_crc5_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow registers and decode state
    logic [5:0]  cfg_group     = CRC_GROUP_RST;
    logic [15:0] cfg_limit     = MAX_OUT_BITS_RST;
    logic [4:0]  dec_crc       = '0;
    logic [5:0]  dec_group_cnt = '0;
    logic [11:0] dec_queue     = '0;
    int          dec_fill      = 0;
    int          dec_delivered = 0;
    logic [1:0]  dec_err       = ST_OK;
    bit          dec_full      = 1'b0;

    b32c5_item_t step_out[$];
    b32c5_item_t predicted_outputs[$];

    int  fail_count     = 0;
    int  chars_sent     = 0;
    bit  tx_burst       = 1'b0;
    bit  sink_hold      = 1'b0;
    bit  random_started = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b1, b32c5_item_t'{8'd0, 4'd0, 1'b1, ST_OK, 16'd0}},
        '{ROW_CHAR, "A",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "9",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, 8'd9,  4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "Z",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'hff, 4'd0, 16'd0, 1'b0, NO_ITEM},
        // lowercase is not part of the alphabet
        '{ROW_CHAR, "i",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b1,
          b32c5_item_t'{8'd0, 4'd0, 1'b1, ST_BAD_SYMBOL, 16'd0}},
        '{ROW_CHAR, 8'h00, 4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b1,
          b32c5_item_t'{8'd0, 4'd0, 1'b1, ST_BAD_SYMBOL, 16'd0}},
        '{ROW_CFG,  8'h00, REG_CRC_GROUP, 16'd2, 1'b0, NO_ITEM},
        '{ROW_CHAR, "C",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "D",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "Q",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b0, NO_ITEM},
        // same group, wrong check symbol: one byte out before the error
        '{ROW_CHAR, "C",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "D",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "A",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b1,
          b32c5_item_t'{8'd0, 4'd0, 1'b1, ST_CRC_MISMATCH, 16'd8}},
        // group size lowered mid-string: next symbol is the check symbol
        '{ROW_CFG,  8'h00, REG_CRC_GROUP, 16'd3, 1'b0, NO_ITEM},
        '{ROW_CHAR, "A",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "B",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CFG,  8'h00, REG_CRC_GROUP, 16'd1, 1'b0, NO_ITEM},
        '{ROW_CHAR, "K",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CFG,  8'h00, REG_CRC_GROUP, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CFG,  8'h00, REG_MAX_OUT_BITS, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "A",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b1, b32c5_item_t'{8'd0, 4'd0, 1'b1, ST_OK, 16'd0}},
        // limit inside the first symbol: leftover bits dropped
        '{ROW_CFG,  8'h00, REG_MAX_OUT_BITS, 16'd3, 1'b0, NO_ITEM},
        '{ROW_CHAR, "Z",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CHAR, "B",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_CFG,  8'h00, REG_MAX_OUT_BITS, 16'hffff, 1'b0, NO_ITEM},
        '{ROW_CFG,  8'h00, REG_CRC_GROUP, 16'd63, 1'b0, NO_ITEM},
        '{ROW_CHAR, "7",   4'd0, 16'd0, 1'b0, NO_ITEM},
        '{ROW_END,  8'h00, 4'd0, 16'd0, 1'b0, NO_ITEM}
    };

    function automatic logic [7:0] sym_char(input int k);
        return ALPHABET[8*(31-k) +: 8];
    endfunction

    function automatic int alpha_index(input logic [7:0] ch);
        for (int k = 0; k < 32; k++)
        begin
            if (sym_char(k) == ch)
            begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic logic [4:0] crc5_next(input logic [4:0] sym, input logic [4:0] acc_in);
        logic [15:0] sr;
        sr = {3'd0, acc_in, 8'd0} ^ {sym, 11'd0};
        repeat (5)
        begin
            sr = sr[15] ? ((sr ^ CRC5_POLY) << 1) : (sr << 1);
        end
        return sr[12:8];
    endfunction

    function automatic string item_str(input b32c5_item_t it);
        return $sformatf("byte=%h bits=%0d fin=%b st=%0d total=%0d",
                         it.out_byte, it.valid_bits, it.final_report,
                         it.status, it.total_bits);
    endfunction

    function automatic b32c5_item_t result_item(input logic [7:0] b, input int n,
                                                input bit fin, input logic [1:0] st);
        b32c5_item_t r;
        r.out_byte     = b;
        r.valid_bits   = 4'(n);
        r.final_report = fin;
        r.status       = st;
        r.total_bits   = 16'(dec_delivered);
        return r;
    endfunction

    // Oldest n queued bits, left-aligned
    function automatic logic [7:0] pop_bits(input int n);
        logic [31:0] wide;
        wide = ({20'd0, dec_queue} >> (dec_fill - n)) << (8 - n);
        dec_fill      = dec_fill - n;
        dec_queue     = dec_queue & 12'((32'd1 << dec_fill) - 1);
        dec_delivered = dec_delivered + n;
        return wide[7:0];
    endfunction

    function automatic void decode_char(input bit eos, input logic [7:0] ch);
        int         limit;
        int         span;
        int         sym;
        int         made;
        logic [7:0] b;
        logic [1:0] st;
        step_out.delete();
        limit = int'(cfg_limit);
        if (eos)
        begin
            if (dec_err == ST_OK && dec_fill > 0 && dec_delivered < limit)
            begin
                span = (dec_fill < limit - dec_delivered) ? dec_fill : limit - dec_delivered;
                b = pop_bits(span);
                step_out.push_back(result_item(b, span, 1'b0, ST_OK));
            end
            if (dec_err != ST_OK)
                st = dec_err;
            else if (cfg_group != 0 && dec_group_cnt != 0)
                st = ST_INCOMPLETE;
            else
                st = ST_OK;
            step_out.push_back(result_item(8'd0, 0, 1'b1, st));
            dec_crc       = '0;
            dec_group_cnt = '0;
            dec_queue     = '0;
            dec_fill      = 0;
            dec_delivered = 0;
            dec_err       = ST_OK;
            dec_full      = 1'b0;
            return;
        end
        if (dec_err != ST_OK || dec_full)
            return;
        if (ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13))
            return;
        sym = alpha_index(ch);
        if (sym < 0)
        begin
            dec_err = ST_BAD_SYMBOL;
            return;
        end
        if (cfg_group != 0)
        begin
            if (dec_group_cnt >= cfg_group)
            begin
                if (dec_crc != 5'(sym))
                    dec_err = ST_CRC_MISMATCH;
                dec_crc       = '0;
                dec_group_cnt = '0;
                return;
            end
            dec_crc       = crc5_next(5'(sym), dec_crc);
            dec_group_cnt = dec_group_cnt + 6'd1;
        end
        // symbol still counts toward the CRC before the space check
        if (dec_delivered >= limit)
        begin
            dec_full = 1'b1;
            return;
        end
        dec_queue = {dec_queue[6:0], 5'(sym)};
        dec_fill  = dec_fill + 5;
        span = (limit - dec_delivered > 8) ? 8 : limit - dec_delivered;
        made = 0;
        while (span > 0 && dec_fill >= span && made < 2)
        begin
            b = pop_bits(span);
            step_out.push_back(result_item(b, span, 1'b0, ST_OK));
            made++;
            span = (limit - dec_delivered > 8) ? 8 : limit - dec_delivered;
        end
    endfunction

    task automatic send_item(input bit eos, input logic [7:0] code, input bit typed,
                             input b32c5_item_t want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.char_code     <= code;
        in_ch.end_of_string <= eos;
        in_ch.valid         <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        decode_char(eos, code);
        if (typed)
            predicted_outputs.push_back(want);
        else
            foreach (step_out[k]) predicted_outputs.push_back(step_out[k]);
    endtask

    // Let the decoder drain before touching registers
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == REG_CRC_GROUP)
            cfg_group = value[5:0];
        else if (idx == REG_MAX_OUT_BITS)
            cfg_limit = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed strings with correct check symbols; some noise and bad checks
    task automatic send_string();
        int         nsym;
        int         ws;
        logic [4:0] sym;
        logic [4:0] g_crc;
        int         g_count;
        logic [7:0] noise;
        g_crc   = '0;
        g_count = 0;
        nsym = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (nsym)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                ws = $urandom_range(0, 6);
                send_item(1'b0, (ws == 6) ? 8'd32 : 8'(9 + ws), 1'b0, NO_ITEM);
            end
            if ($urandom_range(0, 39) == 0)
            begin
                noise = 8'($urandom_range(0, 255));
                send_item(1'b0, noise, 1'b0, NO_ITEM);
                chars_sent++;
            end
            sym = 5'($urandom_range(0, 31));
            send_item(1'b0, sym_char(sym), 1'b0, NO_ITEM);
            chars_sent++;
            if (cfg_group != 0)
            begin
                g_crc = crc5_next(sym, g_crc);
                g_count++;
                if (g_count >= cfg_group)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(1'b0, sym_char($urandom_range(0, 31)), 1'b0, NO_ITEM);
                    else
                        send_item(1'b0, sym_char(g_crc), 1'b0, NO_ITEM);
                    chars_sent++;
                    g_crc   = '0;
                    g_count = 0;
                end
            end
        end
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_ITEM);
        chars_sent++;
    endtask

    initial
    begin : stimulus
        int r;
        logic [15:0] grp;
        logic [15:0] lim;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.char_code     = 8'd0;
        in_ch.end_of_string = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_CRC_GROUP;
        cfg_ch.data         = 16'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            case (directed_rows[i].kind)
                ROW_CFG:
                begin
                    wait_idle();
                    cfg_write(directed_rows[i].reg_index, directed_rows[i].value);
                end
                ROW_END:  send_item(1'b1, directed_rows[i].code, directed_rows[i].typed,
                                    directed_rows[i].want);
                default:  send_item(1'b0, directed_rows[i].code, directed_rows[i].typed,
                                    directed_rows[i].want);
            endcase
        end

        random_started = 1'b1;
        while (chars_sent < RANDOM_CHARS)
        begin
            wait_idle();
            r = $urandom_range(0, 19);
            if (r < 7)
                grp = 16'd0;
            else if (r < 15)
                grp = 16'($urandom_range(1, 6));
            else if (r < 17)
                grp = 16'd63;
            else
                grp = 16'($urandom_range(0, 63));
            r = $urandom_range(0, 19);
            if (r < 12)
                lim = 16'hffff;
            else if (r < 16)
                lim = 16'($urandom_range(0, 64));
            else if (r < 17)
                lim = 16'd0;
            else
                lim = 16'($urandom_range(0, 65535));
            cfg_write(REG_CRC_GROUP, grp);
            cfg_write(REG_MAX_OUT_BITS, lim);
            repeat ($urandom_range(8, 20))
            begin
                tx_burst = ($urandom_range(0, 4) == 0);
                send_string();
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : result_check
        b32c5_item_t got;
        b32c5_item_t want;
        int          wait_left;
        bit          rx_burst;
        out_ch.ready = 1'b0;
        wait_left    = 0;
        rx_burst     = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= (wait_left == 0) && !sink_hold;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.out_byte, out_ch.valid_bits, out_ch.final_report,
                        out_ch.status, out_ch.total_bits};
                if (predicted_outputs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: result with nothing expected: %s",
                                 $realtime, item_str(got));
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (got.out_byte !== want.out_byte || got.valid_bits !== want.valid_bits
                        || got.final_report !== want.final_report
                        || got.status !== want.status || got.total_bits !== want.total_bits)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t: exp %s, got %s",
                                     $realtime, item_str(want), item_str(got));
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                wait_left = rx_burst ? 0 : $urandom_range(0, 16);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
        end
    end

    // Long receiver stall while characters keep coming: result queue fills, input backs up
    initial
    begin : sink_stall
        wait (random_started);
        repeat ($urandom_range(20, 200)) @(posedge clk);
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

// ===== base32_crc5_decoder.f =====
rtl/core/b32c5_pkg.sv
rtl/core/b32c5_if.sv
rtl/core/b32c5_step.sv
rtl/core/b32c5_out_fifo.sv
rtl/core/base32_crc5_decoder.sv
test/tb_base32_crc5_decoder.sv
